>>> sv/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared widths, command codes, status codes and configuration register indices
// of the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 10;
  localparam int ADDR_W   = 32;
  localparam int CNT_W    = 11;
  localparam int STAT_W   = 2;
  localparam int BSIZE_W  = 16;
  localparam int ALIGN_W  = BSIZE_W + 1;
  localparam int PROD_W   = IDX_W + ALIGN_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 32;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

endpackage

>>> sv/fbfl_if.sv
// ----------------------------------------------------------------------------
// fbfl_if
// Valid/ready channels of the allocator: the command channel and the result
// channel.
// ----------------------------------------------------------------------------
interface fbfl_cmd_if import fbfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output cmd, output block_index, input ready);
  modport sink   (input valid, input cmd, input block_index, output ready);
endinterface

interface fbfl_res_if import fbfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  given_index;
  logic [ADDR_W-1:0] given_address;
  logic [CNT_W-1:0]  available;

  modport source (output valid, output status, output given_index,
                  output given_address, output available, input ready);
  modport sink   (input valid, input status, input given_index,
                  input given_address, input available, output ready);
endinterface

>>> sv/fbfl_ram.sv
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module fbfl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> sv/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Fixed-size block allocator that keeps freed blocks on a LIFO stack whose
// links live in a synchronous RAM, and hands out never-used blocks from a
// rising fill mark.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Word
//   in_ch     in         valid/ready        cmd, block_index
//   out_ch    out        valid/ready        status, given_index, given_address,
//                                           available
//   cfg_*     in         write enable only  cfg_index, cfg_data
//
// Init, free, no-op and a fill-mark allocate load the output register on accept.
// A stack-pop allocate reads the head's link from the link RAM on accept and
// takes the new head from the registered read data in ST_READ, once the output
// register is free. One word is in flight at a time; in_ch.ready is high while
// the block is idle and the output register is empty or being drained.
// Reset is synchronous and active low. It empties the stack, clears the fill
// mark, sets the available count to the full pool and loads the configuration
// reset values. The link RAM is not cleared: a link is only read after a free
// has written it.
// A stall on out_ch holds the result in the output register and holds off the
// next command until that word is taken.
//
module fixed_block_free_list_allocator import fbfl_pkg::*; #(
  parameter int MAX_BLOCKS = 1024,
  parameter int WORD_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fbfl_cmd_if.sink             in_ch,
  fbfl_res_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // The index field is 10 bits wide, so at most 1024 blocks can be named.
  localparam int DEPTH = (MAX_BLOCKS < (1 << IDX_W)) ? MAX_BLOCKS : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CNT_W-1:0]   LIM       = CNT_W'(DEPTH);
  localparam logic [ALIGN_W-1:0] WORD_MASK = ALIGN_W'(WORD_BYTES - 1);
  localparam logic [ADDR_W-1:0]  HDR_BYTES = ADDR_W'(WORD_BYTES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Configuration registers.
  logic [ADDR_W-1:0]  pool_base_r;
  logic [BSIZE_W-1:0] block_size_r;
  logic [CNT_W-1:0]   block_count_r;

  // Allocator state.
  logic              state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic              nonempty_r, nonempty_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [CNT_W-1:0]  out_avail_r;

  // Result being loaded this cycle.
  logic              load;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_index;
  logic [ADDR_W-1:0] res_addr;

  // Link RAM ports.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_wdata;
  logic [AW-1:0] ram_rdata;

  logic              out_free, accept;
  logic [CNT_W-1:0]  count;
  logic [ALIGN_W-1:0] aligned;
  logic [IDX_W-1:0]  mul_idx;
  logic [PROD_W-1:0] offset;
  logic [ADDR_W-1:0] addr;

  fbfl_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (head_r),
    .rdata_r (ram_rdata)
  );

  // The block count is read live; zero counts as one and it is capped by the
  // size of the link RAM.
  always_comb begin
    if (block_count_r == '0) begin
      count = CNT_W'(1);
    end else if (block_count_r > LIM) begin
      count = LIM;
    end else begin
      count = block_count_r;
    end
  end

  // Block address: base, one aligned header word, then index times the
  // word-aligned block size, wrapping at 32 bits. One multiplier serves both
  // the fill-mark path and the stack-pop path.
  assign aligned = ({1'b0, block_size_r} + WORD_MASK) & ~WORD_MASK;
  assign mul_idx = (state_r == ST_READ) ? IDX_W'(head_r) : fill_r[IDX_W-1:0];
  assign offset  = PROD_W'(mul_idx) * PROD_W'(aligned);
  assign addr    = pool_base_r + HDR_BYTES + ADDR_W'(offset);

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    nonempty_nxt = nonempty_r;
    fill_nxt     = fill_r;
    total_nxt    = total_r;
    load         = 1'b0;
    res_status   = STAT_OK;
    res_index    = '0;
    res_addr     = '0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = in_ch.block_index[AW-1:0];
    ram_wdata    = nonempty_r ? head_r : in_ch.block_index[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.cmd)
            CMD_INIT: begin
              load         = 1'b1;
              head_nxt     = '0;
              nonempty_nxt = 1'b0;
              fill_nxt     = '0;
              total_nxt    = count;
            end
            CMD_ALLOC: begin
              if (nonempty_r) begin
                // Fetch the link of the head; the pop finishes in ST_READ once out_free is set.
                ram_re    = 1'b1;
                state_nxt = ST_READ;
              end else if (fill_r < count) begin
                load      = 1'b1;
                res_index = fill_r[IDX_W-1:0];
                res_addr  = addr;
                fill_nxt  = fill_r + CNT_W'(1);
                if (total_r != '0) begin
                  total_nxt = total_r - CNT_W'(1);
                end
              end else begin
                load       = 1'b1;
                res_status = STAT_EMPTY;
              end
            end
            CMD_FREE: begin
              load = 1'b1;
              if ({1'b0, in_ch.block_index} >= count) begin
                res_status = STAT_BAD_INDEX;
              end else begin
                // The first block pushed onto an empty stack links to itself.
                ram_we       = 1'b1;
                head_nxt     = in_ch.block_index[AW-1:0];
                nonempty_nxt = 1'b1;
                if (total_r < count) begin
                  total_nxt = total_r + CNT_W'(1);
                end
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          load      = 1'b1;
          res_index = IDX_W'(head_r);
          res_addr  = addr;
          state_nxt = ST_IDLE;
          if (ram_rdata == head_r) begin
            nonempty_nxt = 1'b0;
          end else begin
            head_nxt = ram_rdata;
          end
          if (total_r != '0) begin
            total_nxt = total_r - CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      head_r        <= '0;
      nonempty_r    <= 1'b0;
      fill_r        <= '0;
      total_r       <= LIM;
      out_valid_r   <= 1'b0;
      pool_base_r   <= '0;
      block_size_r  <= BSIZE_W'(8);
      block_count_r <= CNT_W'(1024);
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      nonempty_r  <= nonempty_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POOL_BASE:   pool_base_r   <= cfg_data;
          REG_BLOCK_SIZE:  block_size_r  <= cfg_data[BSIZE_W-1:0];
          REG_BLOCK_COUNT: block_count_r <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_addr_r   <= res_addr;
      out_avail_r  <= total_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.given_index   = out_index_r;
  assign out_ch.given_address = out_addr_r;
  assign out_ch.available     = out_avail_r;

  // A pop is only started when the stack holds a block.
  a_read_needs_stack: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> nonempty_r)
    else $error("link read pending with an empty stack");

  // An allocate on a non-empty stack goes through the link read.
  a_pop_reads_link: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.cmd == CMD_ALLOC && nonempty_r) |=> (state_r == ST_READ))
    else $error("stack pop skipped the link read");

  // The available count never exceeds the link RAM depth.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= LIM)
    else $error("available count above pool capacity");

  // A failed command never reports an allocated block.
  a_fail_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_OK) |->
      (out_index_r == '0 && out_addr_r == '0))
    else $error("failed command carries a block");

endmodule
